[hdl/gbmp_pkg.sv]
`default_nettype none

package gbmp_pkg;

   // controller -> datapath, one pulse per action
   typedef struct packed {
      logic init_clear;
      logic init_start;
      logic init_store;
      logic init_load;
      logic pixel;
      logic mean_start;
      logic out_load;
   } gbmp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_busy;
      logic init_final;
      logic band_end;
      logic mean_last;
      logic out_free;
   } gbmp_status_type;

endpackage

`default_nettype wire

[hdl/gbmp_divider.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module gbmp_divider #(
   parameter int N_BITS = 28,
   parameter int D_BITS = 14
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [N_BITS-1:0] numer,
   input  wire logic [D_BITS-1:0] denom,
   output logic                   busy,
   output logic [N_BITS-1:0]      quot
);

   localparam int CNT_BITS = $clog2(N_BITS + 1);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [N_BITS-1:0]   quot_ff, quot_in;
   logic [D_BITS-1:0]   rem_ff, rem_in;
   logic [D_BITS-1:0]   denom_ff, denom_in;
   logic [D_BITS:0]     trial;
   logic [D_BITS:0]     diff;
   logic                fits;

   assign trial = {rem_ff, quot_ff[N_BITS-1]};
   assign fits  = trial >= {1'b0, denom_ff};
   assign diff  = trial - {1'b0, denom_ff};

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_BITS'(N_BITS);
         quot_in  = numer;
         rem_in   = '0;
         denom_in = denom;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so D_BITS hold it
         rem_in  = fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
         quot_in = {quot_ff[N_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         busy_in = cnt_ff != CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

[hdl/gbmp_datapath.sv]
`default_nettype none

module gbmp_datapath import gbmp_pkg::*; #(
   parameter int MAX_GRID    = 8,
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 16,
   localparam int DIM_BITS   = $clog2(MAX_DIM + 1),
   localparam int G_BITS     = $clog2(MAX_GRID + 1),
   localparam int IDX_BITS   = (MAX_GRID > 1) ? $clog2(MAX_GRID * MAX_GRID) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gbmp_cmd_type           cmd,
   output gbmp_status_type             status,
   input  wire logic [DIM_BITS-1:0]    eff_w,
   input  wire logic [DIM_BITS-1:0]    eff_h,
   input  wire logic [G_BITS-1:0]      g,
   input  wire logic [SAMPLE_BITS-1:0] pixel_value,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [SAMPLE_BITS-1:0]      mean_value,
   output logic [IDX_BITS-1:0]         cell_index,
   output logic                        last_of_image
);

   localparam int GI_BITS   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
   localparam int SUM_BITS  = SAMPLE_BITS + 2 * $clog2(MAX_DIM);
   localparam int AREA_BITS = 2 * DIM_BITS;
   localparam int ACC_BITS  = G_BITS + DIM_BITS;
   localparam int IW        = GI_BITS + G_BITS + 1;
   localparam int NEXT_IDX  = (MAX_GRID > 1) ? 1 : 0;

   // rings: entry 0 is always the current band
   logic [SUM_BITS-1:0] sum_ff [MAX_GRID];
   logic [SUM_BITS-1:0] sum_in [MAX_GRID];
   logic [DIM_BITS-1:0] wid_ff [MAX_GRID];
   logic [DIM_BITS-1:0] wid_in [MAX_GRID];
   logic [DIM_BITS-1:0] hgt_ff [MAX_GRID];
   logic [DIM_BITS-1:0] hgt_in [MAX_GRID];

   logic [DIM_BITS-1:0] col_left_ff, col_left_in;
   logic [DIM_BITS-1:0] row_left_ff, row_left_in;
   logic [GI_BITS-1:0]  col_band_ff, col_band_in;
   logic [GI_BITS-1:0]  row_band_ff, row_band_in;
   logic [GI_BITS-1:0]  mean_k_ff, mean_k_in;
   logic [GI_BITS-1:0]  init_k_ff, init_k_in;
   logic                axis_row_ff, axis_row_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [DIM_BITS-1:0]    prev_ff, prev_in;
   logic [DIM_BITS-1:0]    rh_ff, rh_in;
   logic [GI_BITS-1:0]     mean_row_ff, mean_row_in;
   logic                   last_band_ff, last_band_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic                   last_ff, last_in;

   logic [GI_BITS-1:0]   g_m1;
   logic                 g_one;
   logic                 col_adv;
   logic                 row_end;
   logic                 band_end;
   logic                 init_last;
   logic                 mean_last;
   logic                 out_free;
   logic [DIM_BITS-1:0]  next_w;
   logic [DIM_BITS-1:0]  next_h;
   logic [SUM_BITS-1:0]  head_sum;
   logic [DIM_BITS-1:0]  init_dim;
   logic [ACC_BITS-1:0]  acc_next;
   logic [AREA_BITS-1:0] area;
   logic                 div_start;
   logic [SUM_BITS-1:0]  div_numer;
   logic [AREA_BITS-1:0] div_denom;
   logic                 div_busy;
   logic [SUM_BITS-1:0]  quot;
   logic [DIM_BITS-1:0]  q_dim;
   logic [DIM_BITS-1:0]  new_width;
   logic [IW-1:0]        idx_full;

   assign g_m1      = GI_BITS'(g - G_BITS'(1));
   assign g_one     = g == G_BITS'(1);
   assign col_adv   = col_left_ff == DIM_BITS'(1);
   assign row_end   = col_adv && (col_band_ff == g_m1);
   assign band_end  = row_end && (row_left_ff == DIM_BITS'(1));
   assign init_last = init_k_ff == g_m1;
   assign mean_last = mean_k_ff == g_m1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign next_w    = g_one ? wid_ff[0] : wid_ff[NEXT_IDX];
   assign next_h    = g_one ? hgt_ff[0] : hgt_ff[NEXT_IDX];
   assign head_sum  = sum_ff[0] + SUM_BITS'(pixel_value);
   assign init_dim  = axis_row_ff ? eff_h : eff_w;
   assign acc_next  = acc_ff + ACC_BITS'(init_dim);
   assign area      = AREA_BITS'(wid_ff[0]) * AREA_BITS'(rh_ff);
   assign q_dim     = quot[DIM_BITS-1:0];
   assign new_width = q_dim - prev_ff;
   assign idx_full  = IW'(mean_k_ff) * IW'(g) + IW'(mean_row_ff);

   // band boundaries floor(i*dim/g) during setup, cell means afterwards
   assign div_start = cmd.init_start || cmd.mean_start;
   assign div_numer = cmd.mean_start ? sum_ff[0] : SUM_BITS'(acc_next);
   assign div_denom = cmd.mean_start ? area : AREA_BITS'(g);

   gbmp_divider #(
      .N_BITS(SUM_BITS),
      .D_BITS(AREA_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(div_numer),
      .denom(div_denom),
      .busy (div_busy),
      .quot (quot)
   );

   // ring updates; rotation runs over the first g entries only
   always_comb begin
      sum_in = sum_ff;
      wid_in = wid_ff;
      hgt_in = hgt_ff;
      if (cmd.init_clear) begin
         for (int i = 0; i < MAX_GRID; i++) begin
            sum_in[i] = '0;
         end
      end else if (cmd.pixel) begin
         if (col_adv) begin
            for (int i = 0; i < MAX_GRID; i++) begin
               if (G_BITS'(i + 1) < g) begin
                  sum_in[i] = sum_ff[(i + 1) % MAX_GRID];
                  wid_in[i] = wid_ff[(i + 1) % MAX_GRID];
               end else if (G_BITS'(i + 1) == g) begin
                  sum_in[i] = head_sum;
                  wid_in[i] = wid_ff[0];
               end
            end
         end else begin
            sum_in[0] = head_sum;
         end
         if (band_end) begin
            for (int i = 0; i < MAX_GRID; i++) begin
               if (G_BITS'(i + 1) < g) begin
                  hgt_in[i] = hgt_ff[(i + 1) % MAX_GRID];
               end else if (G_BITS'(i + 1) == g) begin
                  hgt_in[i] = hgt_ff[0];
               end
            end
         end
      end else if (cmd.mean_start) begin
         // sum taken by the divider, zero shifts in behind it
         for (int i = 0; i < MAX_GRID; i++) begin
            if (G_BITS'(i + 1) < g) begin
               sum_in[i] = sum_ff[(i + 1) % MAX_GRID];
               wid_in[i] = wid_ff[(i + 1) % MAX_GRID];
            end else if (G_BITS'(i + 1) == g) begin
               sum_in[i] = '0;
               wid_in[i] = wid_ff[0];
            end
         end
      end
      if (cmd.init_store) begin
         for (int i = 0; i < MAX_GRID; i++) begin
            if (init_k_ff == GI_BITS'(i)) begin
               if (axis_row_ff) begin
                  hgt_in[i] = new_width;
               end else begin
                  wid_in[i] = new_width;
               end
            end
         end
      end
   end

   always_comb begin
      col_left_in  = col_left_ff;
      row_left_in  = row_left_ff;
      col_band_in  = col_band_ff;
      row_band_in  = row_band_ff;
      mean_k_in    = mean_k_ff;
      init_k_in    = init_k_ff;
      axis_row_in  = axis_row_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      rh_in        = rh_ff;
      mean_row_in  = mean_row_ff;
      last_band_in = last_band_ff;
      mean_in      = mean_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.init_clear) begin
         init_k_in   = '0;
         axis_row_in = 1'b0;
         acc_in      = '0;
         prev_in     = '0;
      end
      if (cmd.init_start) begin
         acc_in = acc_next;
      end
      if (cmd.init_store) begin
         if (init_last) begin
            if (!axis_row_ff) begin
               axis_row_in = 1'b1;
               init_k_in   = '0;
               acc_in      = '0;
               prev_in     = '0;
            end
         end else begin
            init_k_in = init_k_ff + GI_BITS'(1);
            prev_in   = q_dim;
         end
      end
      if (cmd.init_load) begin
         col_left_in = wid_ff[0];
         row_left_in = hgt_ff[0];
         col_band_in = '0;
         row_band_in = '0;
      end
      if (cmd.pixel) begin
         if (col_adv) begin
            col_left_in = next_w;
            col_band_in = row_end ? '0 : col_band_ff + GI_BITS'(1);
         end else begin
            col_left_in = col_left_ff - DIM_BITS'(1);
         end
         if (row_end) begin
            if (band_end) begin
               row_left_in  = next_h;
               row_band_in  = (row_band_ff == g_m1) ? '0 : row_band_ff + GI_BITS'(1);
               rh_in        = hgt_ff[0];
               mean_row_in  = row_band_ff;
               last_band_in = row_band_ff == g_m1;
               mean_k_in    = '0;
            end else begin
               row_left_in = row_left_ff - DIM_BITS'(1);
            end
         end
      end
      if (cmd.out_load) begin
         mean_k_in    = mean_k_ff + GI_BITS'(1);
         mean_in      = quot[SAMPLE_BITS-1:0];
         idx_in       = idx_full[IDX_BITS-1:0];
         last_in      = last_band_ff && mean_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_left_ff  <= '0;
         row_left_ff  <= '0;
         col_band_ff  <= '0;
         row_band_ff  <= '0;
         mean_k_ff    <= '0;
         init_k_ff    <= '0;
         axis_row_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_left_ff  <= col_left_in;
         row_left_ff  <= row_left_in;
         col_band_ff  <= col_band_in;
         row_band_ff  <= row_band_in;
         mean_k_ff    <= mean_k_in;
         init_k_ff    <= init_k_in;
         axis_row_ff  <= axis_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      wid_ff       <= wid_in;
      hgt_ff       <= hgt_in;
      acc_ff       <= acc_in;
      prev_ff      <= prev_in;
      rh_ff        <= rh_in;
      mean_row_ff  <= mean_row_in;
      last_band_ff <= last_band_in;
      mean_ff      <= mean_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
   end

   assign status.div_busy   = div_busy;
   assign status.init_final = init_last && axis_row_ff;
   assign status.band_end   = band_end;
   assign status.mean_last  = mean_last;
   assign status.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign mean_value    = mean_ff;
   assign cell_index    = idx_ff;
   assign last_of_image = last_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while full");

   a_pixel_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.pixel |-> !div_busy)
      else $error("pixel taken while divider busy");

   a_area: assert property (@(posedge clock) disable iff (reset)
      cmd.mean_start |-> area != '0)
      else $error("empty cell reached the divider");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.init_load |=> (col_left_ff != '0) && (row_left_ff != '0))
      else $error("band countdown loaded with zero");

endmodule

`default_nettype wire

[hdl/gbmp_ctrl.sv]
`default_nettype none

module gbmp_ctrl import gbmp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            restart,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire gbmp_status_type status,
   output gbmp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      INIT_CLR,
      INIT_START,
      INIT_WAIT,
      INIT_LOAD,
      RUN,
      MEAN_START,
      MEAN_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         INIT_CLR: begin
            cmd.init_clear = 1'b1;
            state_in       = INIT_START;
         end
         INIT_START: begin
            cmd.init_start = 1'b1;
            state_in       = INIT_WAIT;
         end
         INIT_WAIT: begin
            if (!status.div_busy) begin
               cmd.init_store = 1'b1;
               state_in       = status.init_final ? INIT_LOAD : INIT_START;
            end
         end
         INIT_LOAD: begin
            cmd.init_load = 1'b1;
            state_in      = RUN;
         end
         RUN: begin
            if (req_valid) begin
               cmd.pixel = 1'b1;
               if (status.band_end) begin
                  state_in = MEAN_START;
               end
            end
         end
         MEAN_START: begin
            cmd.mean_start = 1'b1;
            state_in       = MEAN_WAIT;
         end
         MEAN_WAIT: begin
            if (!status.div_busy && status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.mean_last ? RUN : MEAN_START;
            end
         end
         default: begin
            state_in = INIT_CLR;
         end
      endcase
      if (restart) begin
         state_in = INIT_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == RUN;

endmodule

`default_nettype wire

[hdl/grid_block_mean_pooling_core.sv]
`default_nettype none

// Grid mean pooling over a raster-order image. Pixels enter row by row on
// req_*, one word per cycle while the core runs. The image is cut into a
// g x g grid (bands start at floor(i*dim/g)); on the last pixel of each row
// band the core stops taking pixels and produces g cell means, in column
// band order, through one shared restoring divider at one quotient bit per
// cycle. The last mean may still sit in the output register while the next
// pixels are taken. After reset and after every register write the core
// computes its band sizes with the same divider, and during that time no
// pixel is taken. A register write restarts the image.
// Registers: 0x0 image_width, 0x4 image_height, 0x8 grid_count.
module grid_block_mean_pooling_core import gbmp_pkg::*; #(
   parameter int MAX_GRID    = 8,
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 16,
   localparam int IDX_BITS   = (MAX_GRID > 1) ? $clog2(MAX_GRID * MAX_GRID) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_pixel_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0]      rsp_mean_value,
   output logic [IDX_BITS-1:0]         rsp_cell_index,
   output logic                        rsp_last_of_image,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [3:0]             paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int DIM_BITS      = $clog2(MAX_DIM + 1);
   localparam int G_BITS        = $clog2(MAX_GRID + 1);
   localparam int CFG_DIM_BITS  = 7;
   localparam int CFG_GRID_BITS = 4;
   localparam int EXT           = (DIM_BITS > CFG_DIM_BITS) ? DIM_BITS : CFG_DIM_BITS;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_GRID   = 2'd2;

   logic [CFG_DIM_BITS-1:0]  width_ff, width_in;
   logic [CFG_DIM_BITS-1:0]  height_ff, height_in;
   logic [CFG_GRID_BITS-1:0] grid_ff, grid_in;
   logic                     wr;
   logic                     restart;

   logic [EXT-1:0]      w_ext, h_ext, g_ext;
   logic [DIM_BITS-1:0] eff_w, eff_h, min_dim;
   logic [G_BITS-1:0]   eff_g;

   gbmp_cmd_type    cmd;
   gbmp_status_type status;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      grid_in   = grid_ff;
      restart   = 1'b0;
      if (wr) begin
         case (paddr[3:2])
            REG_WIDTH: begin
               width_in = pwdata[CFG_DIM_BITS-1:0];
               restart  = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = pwdata[CFG_DIM_BITS-1:0];
               restart   = 1'b1;
            end
            REG_GRID: begin
               grid_in = pwdata[CFG_GRID_BITS-1:0];
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_BITS'(32);
         height_ff <= CFG_DIM_BITS'(32);
         grid_ff   <= CFG_GRID_BITS'(4);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         grid_ff   <= grid_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         REG_GRID:   prdata = 32'(grid_ff);
         default:    prdata = '0;
      endcase
   end

   // zero reads as one, oversize clamps; grid never exceeds the shorter side
   always_comb begin
      w_ext = EXT'(width_ff);
      h_ext = EXT'(height_ff);
      g_ext = EXT'(grid_ff);
      if (w_ext == '0) begin
         w_ext = EXT'(1);
      end else if (w_ext > EXT'(MAX_DIM)) begin
         w_ext = EXT'(MAX_DIM);
      end
      if (h_ext == '0) begin
         h_ext = EXT'(1);
      end else if (h_ext > EXT'(MAX_DIM)) begin
         h_ext = EXT'(MAX_DIM);
      end
      eff_w   = DIM_BITS'(w_ext);
      eff_h   = DIM_BITS'(h_ext);
      min_dim = (eff_w < eff_h) ? eff_w : eff_h;
      if (g_ext == '0) begin
         g_ext = EXT'(1);
      end else if (g_ext > EXT'(MAX_GRID)) begin
         g_ext = EXT'(MAX_GRID);
      end
      if (g_ext > EXT'(min_dim)) begin
         g_ext = EXT'(min_dim);
      end
      eff_g = G_BITS'(g_ext);
   end

   gbmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   gbmp_datapath #(
      .MAX_GRID   (MAX_GRID),
      .MAX_DIM    (MAX_DIM),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .g            (eff_g),
      .pixel_value  (req_pixel_value),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .mean_value   (rsp_mean_value),
      .cell_index   (rsp_cell_index),
      .last_of_image(rsp_last_of_image)
   );

endmodule

`default_nettype wire
